FILE: rtl/gccd_pkg.sv
// Shared types and constants for the greedy coin change dispenser.
// Holds transaction structs, function codes and chain link types.
// No dependencies; imported by gccd_cell and the core top level.
`default_nettype none

package gccd_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int COUNT_BITS  = 16;
  localparam int MAX_RESULTS = 8;

  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 3;
  localparam int VAL_W    = 16;
  localparam int QTY_W    = 16;
  localparam int AMT_W    = 20;
  localparam int USED_W   = 16;

  localparam int TAKE_W   = (COUNT_BITS < AMT_W) ? COUNT_BITS : AMT_W;
  localparam int CMP_W    = (COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W;
  localparam int PROD_W   = COUNT_BITS + VAL_W;
  localparam int STEP_W   = $clog2(AMT_W);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_TEST  = 2'd2,
    FUNC_MAKE  = 2'd3
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [IDX_W-1:0]  slot_index;
    logic [VAL_W-1:0]  denom;
    logic [QTY_W-1:0]  quantity;
    logic [AMT_W-1:0]  amount_cents;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [VAL_W-1:0]  paid_value;
    logic [USED_W-1:0] num_coins;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic              go;
    logic              tok;
    logic [AMT_W-1:0]  rem;
  } link_t;

  typedef struct packed {
    logic [VAL_W-1:0]      wr_value;
    logic [COUNT_BITS-1:0] wr_count;
    logic [VAL_W-1:0]      qval;
    logic                  ack;
  } ctl_t;

  typedef struct packed {
    logic              valid;
    logic [VAL_W-1:0]  value;
    logic [USED_W-1:0] used;
    logic              last;
  } offer_t;

endpackage

`default_nettype wire

FILE: rtl/greedy_coin_change_dispenser_core.sv
// Top level of the greedy coin change dispenser: controller and slot chain.
// Instantiates NUM_SLOTS gccd_cell stages; depends on gccd_pkg.
//
//   channel  | valid     | stall     | payload
//   request  | req_valid | req_stall | req (gccd_pkg::req_t)
//   result   | rsp_valid | rsp_stall | rsp (gccd_pkg::rsp_t)
//
// Load and query are answered from a reply state. Test and make first walk the
// slot chain from the top slot down: a slot that is unused or larger than what
// is left passes the amount straight on, a slot that can pay runs its serial
// quotient and a fix-up step. A make that dispenses then walks a dispense token
// down the chain; each dispensing slot waits until the output register is free.
// Reset clears all slots to unused and empty. A request waits while a result
// is pending in the output register only if a new result must be written.
`default_nettype none

module greedy_coin_change_dispenser_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire gccd_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output gccd_pkg::rsp_t      rsp
);
  import gccd_pkg::*;

  typedef enum logic [1:0] {
    T_IDLE,
    T_PASS,
    T_EMIT,
    T_REPLY
  } tstate_t;

  tstate_t              state;
  func_t                func_q;
  logic                 reply_ok;
  logic                 head_go;
  logic                 head_tok;
  logic [AMT_W-1:0]     head_rem;

  link_t                link [NUM_SLOTS+1];
  logic [NUM_SLOTS:0]   nz;
  logic [NUM_SLOTS-1:0] wr;
  logic [NUM_SLOTS-1:0] taking;
  logic [NUM_SLOTS-1:0] hit;
  offer_t               offer [NUM_SLOTS];
  offer_t               offer_any;
  ctl_t                 ctl;
  logic                 rsp_free;
  logic                 pass_ok;
  logic                 idx_ok;

  assign req_stall = state != T_IDLE;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign idx_ok    = int'(req.slot_index) < NUM_SLOTS;
  assign pass_ok   = link[0].rem == '0;

  assign link[NUM_SLOTS] = '{go: head_go, tok: head_tok, rem: head_rem};
  assign nz[0]           = 1'b0;

  always_comb begin
    offer_any = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      offer_any = offer_any | offer[i];
    end
  end

  always_comb begin
    ctl.wr_value = req.denom;
    ctl.wr_count = COUNT_BITS'(req.quantity);
    ctl.qval     = req.denom;
    ctl.ack      = (state == T_EMIT) && rsp_free && offer_any.valid;
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      wr[i] = (state == T_IDLE) && req_valid && (req.func == FUNC_LOAD) &&
              (int'(req.slot_index) == i);
    end
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    gccd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr       (wr[g]),
      .ctl      (ctl),
      .link_in  (link[g+1]),
      .link_out (link[g]),
      .nz_in    (nz[g]),
      .nz_out   (nz[g+1]),
      .taking   (taking[g]),
      .hit      (hit[g]),
      .offer    (offer[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      rsp_valid <= 1'b0;
      head_go   <= 1'b0;
      head_tok  <= 1'b0;
    end else begin
      head_go  <= 1'b0;
      head_tok <= 1'b0;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (req_valid) begin
            func_q <= req.func;
            case (req.func)
              FUNC_LOAD: begin
                reply_ok <= idx_ok;
                state    <= T_REPLY;
              end
              FUNC_QUERY: begin
                reply_ok <= |hit;
                state    <= T_REPLY;
              end
              FUNC_TEST, FUNC_MAKE: begin
                head_go  <= 1'b1;
                head_rem <= req.amount_cents;
                state    <= T_PASS;
              end
              default: begin
                state <= T_IDLE;
              end
            endcase
          end
        end
        T_PASS: begin
          if (link[0].go) begin
            if (func_q == FUNC_MAKE && pass_ok && nz[NUM_SLOTS] &&
                $countones(taking) <= MAX_RESULTS) begin
              head_tok <= 1'b1;
              state    <= T_EMIT;
            end else begin
              reply_ok <= pass_ok && ($countones(taking) <= MAX_RESULTS ||
                                      func_q == FUNC_TEST);
              state    <= T_REPLY;
            end
          end
        end
        T_EMIT: begin
          if (ctl.ack) begin
            rsp_valid      <= 1'b1;
            rsp.ok         <= 1'b1;
            rsp.paid_value <= offer_any.value;
            rsp.num_coins  <= offer_any.used;
            rsp.last       <= offer_any.last;
          end
          if (link[0].tok) begin
            state <= T_IDLE;
          end
        end
        T_REPLY: begin
          if (rsp_free) begin
            rsp_valid      <= 1'b1;
            rsp.ok         <= reply_ok;
            rsp.paid_value <= '0;
            rsp.num_coins  <= '0;
            rsp.last       <= 1'b1;
            state          <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gccd_cell.sv
// One coin slot of the dispenser chain: value, count, coins taken.
// Runs a bit-serial quotient on the amount handed down from above.
// Depends on gccd_pkg.
`default_nettype none

module gccd_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire gccd_pkg::ctl_t  ctl,
  input  wire gccd_pkg::link_t link_in,
  output gccd_pkg::link_t      link_out,
  input  wire logic            nz_in,
  output logic                 nz_out,
  output logic                 taking,
  output logic                 hit,
  output gccd_pkg::offer_t     offer
);
  import gccd_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_DIV,
    C_FIX,
    C_OFFER
  } cstate_t;

  cstate_t                 st;
  logic [VAL_W-1:0]        value;
  logic [COUNT_BITS-1:0]   count;
  logic [TAKE_W-1:0]       take;
  logic [AMT_W-1:0]        rem_hold;
  logic [AMT_W-1:0]        dq;
  logic [VAL_W-1:0]        pr;
  logic [STEP_W-1:0]       step;
  logic [PROD_W-1:0]       prod;
  logic                    go_o;
  logic                    tok_o;
  logic [AMT_W-1:0]        rem_o;

  logic [VAL_W:0]          trial;
  logic                    ge;
  logic                    capped;

  always_comb begin
    trial  = {pr, dq[AMT_W-1]};
    ge     = trial >= {1'b0, value};
    capped = CMP_W'(dq) > CMP_W'(count);
  end

  assign link_out = '{go: go_o, tok: tok_o, rem: rem_o};
  assign taking   = take != '0;
  assign nz_out   = nz_in | taking;
  assign hit      = (value == ctl.qval) && (ctl.qval != '0);

  always_comb begin
    offer       = '0;
    offer.valid = st == C_OFFER;
    if (st == C_OFFER) begin
      offer.value = value;
      offer.used  = USED_W'(take);
      offer.last  = !nz_in;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(count) * PROD_W'(value);
    if (rst) begin
      st    <= C_IDLE;
      value <= '0;
      count <= '0;
      take  <= '0;
      go_o  <= 1'b0;
      tok_o <= 1'b0;
    end else begin
      go_o  <= 1'b0;
      tok_o <= 1'b0;
      if (wr) begin
        value <= ctl.wr_value;
        count <= ctl.wr_count;
      end
      case (st)
        C_IDLE: begin
          if (link_in.go) begin
            rem_hold <= link_in.rem;
            dq       <= link_in.rem;
            pr       <= '0;
            step     <= '0;
            if (value == '0 || link_in.rem < AMT_W'(value)) begin
              take  <= '0;
              go_o  <= 1'b1;
              rem_o <= link_in.rem;
            end else begin
              st <= C_DIV;
            end
          end else if (link_in.tok) begin
            if (take == '0) begin
              tok_o <= 1'b1;
            end else begin
              st <= C_OFFER;
            end
          end
        end
        C_DIV: begin
          pr   <= ge ? VAL_W'(trial - {1'b0, value}) : VAL_W'(trial);
          dq   <= {dq[AMT_W-2:0], ge};
          step <= step + 1'b1;
          if (step == STEP_W'(AMT_W - 1)) begin
            st <= C_FIX;
          end
        end
        C_FIX: begin
          if (capped) begin
            take  <= TAKE_W'(count);
            rem_o <= rem_hold - AMT_W'(prod);
          end else begin
            take  <= TAKE_W'(dq);
            rem_o <= AMT_W'(pr);
          end
          go_o <= 1'b1;
          st   <= C_IDLE;
        end
        C_OFFER: begin
          if (ctl.ack) begin
            count <= count - COUNT_BITS'(take);
            tok_o <= 1'b1;
            st    <= C_IDLE;
          end
        end
        default: begin
          st <= C_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for greedy_coin_change_dispenser_core: drives load, query,
// test and make transactions and predicts every result from a shadow coin table.
// Depends on gccd_pkg and the core RTL only.
`default_nettype none

module tb_top;
  import gccd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_ITEMS   = 120;
  localparam int MAX_REPORTS    = 10;

  class change_board;
    logic [VAL_W-1:0]      coin_val [NUM_SLOTS];
    logic [COUNT_BITS-1:0] coin_cnt [NUM_SLOTS];
    rsp_t                  pending [$];
    int                    requests;
    int                    results;
    int                    payouts;
    int                    refusals;
    int                    errors;

    function void clear_table();
      foreach (coin_val[i]) begin
        coin_val[i] = '0;
        coin_cnt[i] = '0;
      end
    endfunction

    function void queue_result(logic ok, logic [VAL_W-1:0] value,
                               logic [USED_W-1:0] used, logic last);
      rsp_t e;
      e.ok         = ok;
      e.paid_value = value;
      e.num_coins  = used;
      e.last       = last;
      pending.insert(pending.size(), e);
    endfunction

    function void note_request(req_t r);
      int unsigned rem;
      int unsigned q;
      int unsigned take [NUM_SLOTS];
      int          paying;
      int          k;
      logic        hit;
      requests++;
      case (r.func)
        FUNC_LOAD: begin
          if (int'(r.slot_index) < NUM_SLOTS) begin
            coin_val[r.slot_index] = r.denom;
            coin_cnt[r.slot_index] = r.quantity[COUNT_BITS-1:0];
            queue_result(1'b1, '0, '0, 1'b1);
          end else begin
            queue_result(1'b0, '0, '0, 1'b1);
          end
        end
        FUNC_QUERY: begin
          hit = 1'b0;
          foreach (coin_val[i])
            if (r.denom != '0 && coin_val[i] == r.denom)
              hit = 1'b1;
          queue_result(hit, '0, '0, 1'b1);
        end
        default: begin
          rem    = r.amount_cents;
          paying = 0;
          for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            q = 0;
            if (coin_val[i] != '0) begin
              q = rem / coin_val[i];
              if (q > coin_cnt[i])
                q = coin_cnt[i];
              rem -= q * coin_val[i];
            end
            take[i] = q;
            if (q != 0)
              paying++;
          end
          if (r.func == FUNC_TEST) begin
            queue_result(rem == 0, '0, '0, 1'b1);
          end else if (rem != 0 || paying > MAX_RESULTS) begin
            refusals++;
            queue_result(1'b0, '0, '0, 1'b1);
          end else if (paying == 0) begin
            payouts++;
            queue_result(1'b1, '0, '0, 1'b1);
          end else begin
            payouts++;
            k = 0;
            for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
              if (take[i] != 0) begin
                coin_cnt[i] -= COUNT_BITS'(take[i]);
                k++;
                queue_result(1'b1, coin_val[i], USED_W'(take[i]), k == paying);
              end
            end
          end
        end
      endcase
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      results++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: unexpected result ok=%0d value=%0d used=%0d last=%0d",
                   got.ok, got.paid_value, got.num_coins, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.ok !== want.ok || got.paid_value !== want.paid_value ||
          got.num_coins !== want.num_coins || got.last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"ERROR: result %0d expected ok=%0d value=%0d used=%0d last=%0d,",
                    " %s%0d %s%0d %s%0d %s%0d"},
                   results, want.ok, want.paid_value, want.num_coins, want.last,
                   "got ok=", got.ok, "value=", got.paid_value,
                   "used=", got.num_coins, "last=", got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  change_board board;
  int          burst_left   = 0;
  int          idle_cycles  = 0;
  int          hold_left    = 0;
  int          seg_left     = 0;
  int          seg_mode     = 0;
  int          sent         = 0;
  bit          steady       = 1'b0;
  bit          hold_request = 1'b0;

  greedy_coin_change_dispenser_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (req_valid && !req_stall)
        board.note_request(req);
      if (rsp_valid && !rsp_stall)
        board.check_result(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        rsp_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 60);
        end
        seg_left--;
        case (seg_mode)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 3) == 0);
          2: rsp_stall <= ($urandom_range(0, 3) != 0);
          default: rsp_stall <= (seg_left % 3 == 0);
        endcase
      end
    end
  end

  function automatic req_t rand_req();
    req_t r;
    r.func         = func_t'($urandom_range(0, 3));
    r.slot_index   = IDX_W'($urandom);
    r.denom        = VAL_W'($urandom);
    r.quantity     = QTY_W'($urandom);
    r.amount_cents = AMT_W'($urandom);
    return r;
  endfunction

  function automatic req_t build_req(func_t f, int unsigned idx, int unsigned value,
                                     int unsigned qty, int unsigned amt);
    req_t r;
    r.func         = f;
    r.slot_index   = IDX_W'(idx);
    r.denom        = VAL_W'(value);
    r.quantity     = QTY_W'(qty);
    r.amount_cents = AMT_W'(amt);
    return r;
  endfunction

  function automatic logic [AMT_W-1:0] payable_amount();
    int unsigned sum;
    int unsigned lim;
    sum = 0;
    foreach (board.coin_val[i]) begin
      lim = (board.coin_cnt[i] < 5) ? board.coin_cnt[i] : 5;
      sum += board.coin_val[i] * $urandom_range(0, lim);
    end
    return AMT_W'(sum);
  endfunction

  task automatic send_request(req_t r);
    if (burst_left == 0 && !steady) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
    end
    if (burst_left > 0)
      burst_left--;
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic fill_table();
    req_t        r;
    int unsigned value;
    int unsigned cnt;
    int unsigned base;
    base = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      case ($urandom_range(0, 9))
        0: value = 0;
        1: value = (base == 0) ? 1 : base;
        default: begin
          base  = base + $urandom_range(1, base + 4);
          if (base > 65535)
            base = 65535;
          value = base;
        end
      endcase
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 15);
      r            = rand_req();
      r.func       = FUNC_LOAD;
      r.slot_index = IDX_W'(i);
      r.denom      = VAL_W'(value);
      r.quantity   = QTY_W'(cnt);
      send_request(r);
    end
  endtask

  initial begin
    req_t r;
    int   pick;
    int   start_count;
    board = new;
    board.clear_table();
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_request(build_req(FUNC_QUERY, 0, 0, 0, 0));
    send_request(build_req(FUNC_TEST, 0, 0, 0, 0));
    send_request(build_req(FUNC_MAKE, 0, 0, 0, 0));
    send_request(build_req(FUNC_MAKE, 0, 0, 0, 1));
    send_request(build_req(FUNC_LOAD, 0, 1, 0, 50));
    send_request(build_req(FUNC_LOAD, 0, 1, 50, 0));
    send_request(build_req(FUNC_LOAD, 1, 5, 20, 0));
    send_request(build_req(FUNC_LOAD, 2, 10, 10, 0));
    send_request(build_req(FUNC_LOAD, 3, 25, 8, 0));
    send_request(build_req(FUNC_LOAD, 4, 25, 4, 0));
    send_request(build_req(FUNC_LOAD, 5, 100, 0, 0));
    send_request(build_req(FUNC_LOAD, 6, 0, 9, 0));
    send_request(build_req(FUNC_LOAD, 7, 65535, 65535, 0));
    send_request(build_req(FUNC_QUERY, 0, 25, 0, 0));
    send_request(build_req(FUNC_QUERY, 0, 0, 0, 0));
    send_request(build_req(FUNC_QUERY, 0, 65535, 0, 0));
    send_request(build_req(FUNC_TEST, 0, 0, 0, 1048575));
    send_request(build_req(FUNC_MAKE, 0, 0, 0, 1048575));
    send_request(build_req(FUNC_MAKE, 0, 0, 0, 137));
    send_request(build_req(FUNC_MAKE, 0, 0, 0, 100000));
    send_request(build_req(FUNC_LOAD, 2, 5000, 3, 0));
    send_request(build_req(FUNC_MAKE, 0, 0, 0, 5037));
    send_request(build_req(FUNC_LOAD, 0, 1, 0, 0));
    send_request(build_req(FUNC_TEST, 0, 0, 0, 3));
    send_request(build_req(FUNC_MAKE, 0, 0, 0, 3));

    // hold the result side off while the sender keeps offering transactions
    steady       = 1'b1;
    hold_request = 1'b1;
    start_count  = sent;
    while (sent - start_count < RANDOM_ITEMS) begin
      if (sent - start_count >= 24)
        steady = 1'b0;
      if (sent == start_count || $urandom_range(0, 3) == 0)
        fill_table();
      repeat ($urandom_range(4, 8)) begin
        r    = rand_req();
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          r.func         = FUNC_MAKE;
          r.amount_cents = payable_amount();
        end else if (pick < 12) begin
          r.func         = FUNC_TEST;
          r.amount_cents = payable_amount();
        end else if (pick < 14) begin
          r.func         = FUNC_MAKE;
          r.amount_cents = AMT_W'($urandom_range(0, 3000));
        end else if (pick < 16) begin
          r.func  = FUNC_QUERY;
          r.denom = board.coin_val[$urandom_range(0, NUM_SLOTS - 1)];
        end else if (pick < 18) begin
          r.func = FUNC_LOAD;
        end
        send_request(r);
      end
    end
    req_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d change payouts, %0d refused, %0d results checked",
             board.requests, board.payouts, board.refusals, board.results);
    $display("Mismatches: %0d, results still outstanding: %0d",
             board.errors, board.pending.size());
    if (board.errors == 0 && board.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
